/* hdl/cp437_pkg.sv */
// Types, constants and lookup functions for the code page 437 encoder core.
// Self-contained; used by cp437_encoder_with_fallback_core.
package cp437_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned GlyphCount = 128;
  localparam int unsigned GlyphIdxWidth = $clog2(GlyphCount);

  localparam logic [CpWidth-1:0] CpMaxValid = 21'h10FFFF;
  localparam logic [CpWidth-1:0] CpSurrLo = 21'h00D800;
  localparam logic [CpWidth-1:0] CpSurrHi = 21'h00DFFF;
  localparam logic [CpWidth-1:0] CpReplChar = 21'h00FFFD;
  localparam logic [CpWidth-1:0] CpAsciiMax = 21'h00007F;
  localparam logic [CpWidth-1:0] ReplResetValue = 21'd63;

  localparam logic [0:0] OP_ENCODE = 1'b0;
  localparam logic [0:0] OP_DECODE = 1'b1;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_APPROX = 2'd1;
  localparam logic [1:0] KIND_REPL = 2'd2;

  typedef struct packed {
    logic [0:0]         opcode;
    logic [CpWidth-1:0] code_point;
    logic [7:0]         byte_value;
  } in_word_t;

  typedef struct packed {
    logic [0:0]         success;
    logic [7:0]         encoded_byte;
    logic [CpWidth-1:0] output_code_point;
    logic [1:0]         kind;
  } out_word_t;

  typedef struct packed {
    logic                 ok;
    logic [ByteWidth-1:0] enc_byte;
  } enc_t;

  // Upper half of the code page: byte 0x80 + i decodes to GLYPH_TAB[i].
  localparam logic [CpWidth-1:0] GLYPH_TAB [GlyphCount] = '{
    21'h00C7, 21'h00FC, 21'h00E9, 21'h00E2, 21'h00E4, 21'h00E0, 21'h00E5, 21'h00E7,
    21'h00EA, 21'h00EB, 21'h00E8, 21'h00EF, 21'h00EE, 21'h00EC, 21'h00C4, 21'h00C5,
    21'h00C9, 21'h00E6, 21'h00C6, 21'h00F4, 21'h00F6, 21'h00F2, 21'h00FB, 21'h00F9,
    21'h00FF, 21'h00D6, 21'h00DC, 21'h00A2, 21'h00A3, 21'h00A5, 21'h20A7, 21'h0192,
    21'h00E1, 21'h00ED, 21'h00F3, 21'h00FA, 21'h00F1, 21'h00D1, 21'h00AA, 21'h00BA,
    21'h00BF, 21'h2310, 21'h00AC, 21'h00BD, 21'h00BC, 21'h00A1, 21'h00AB, 21'h00BB,
    21'h2591, 21'h2592, 21'h2593, 21'h2502, 21'h2524, 21'h2561, 21'h2562, 21'h2556,
    21'h2555, 21'h2563, 21'h2551, 21'h2557, 21'h255D, 21'h255C, 21'h255B, 21'h2510,
    21'h2514, 21'h2534, 21'h252C, 21'h251C, 21'h2500, 21'h253C, 21'h255E, 21'h255F,
    21'h255A, 21'h2554, 21'h2569, 21'h2566, 21'h2560, 21'h2550, 21'h256C, 21'h2567,
    21'h2568, 21'h2564, 21'h2565, 21'h2559, 21'h2558, 21'h2552, 21'h2553, 21'h256B,
    21'h256A, 21'h2518, 21'h250C, 21'h2588, 21'h2584, 21'h258C, 21'h2590, 21'h2580,
    21'h03B1, 21'h00DF, 21'h0393, 21'h03C0, 21'h03A3, 21'h03C3, 21'h00B5, 21'h03C4,
    21'h03A6, 21'h0398, 21'h03A9, 21'h03B4, 21'h221E, 21'h03C6, 21'h03B5, 21'h2229,
    21'h2261, 21'h00B1, 21'h2265, 21'h2264, 21'h2320, 21'h2321, 21'h00F7, 21'h2248,
    21'h00B0, 21'h2219, 21'h00B7, 21'h221A, 21'h207F, 21'h00B2, 21'h25A0, 21'h00A0
  };

  // Surrogates and values beyond the Unicode range become U+FFFD.
  function automatic logic [CpWidth-1:0] sanitize(logic [CpWidth-1:0] cp);
    if (cp > CpMaxValid || (cp >= CpSurrLo && cp <= CpSurrHi)) begin
      return CpReplChar;
    end
    return cp;
  endfunction

  function automatic logic [CpWidth-1:0] decode_byte(logic [ByteWidth-1:0] b);
    if (!b[ByteWidth-1]) begin
      return {{(CpWidth-ByteWidth){1'b0}}, b};
    end
    return GLYPH_TAB[b[GlyphIdxWidth-1:0]];
  endfunction

  // Exact encode of a sanitized code point. The table holds no duplicates,
  // so the matching indexes can simply be OR-ed together.
  function automatic enc_t encode_exact(logic [CpWidth-1:0] cp);
    enc_t                     res;
    logic [GlyphIdxWidth-1:0] idx;
    logic                     hit;
    idx = '0;
    hit = 1'b0;
    for (int i = 0; i < GlyphCount; i++) begin
      if (GLYPH_TAB[i] == cp) begin
        hit = 1'b1;
        idx = idx | GlyphIdxWidth'(i);
      end
    end
    if (cp <= CpAsciiMax) begin
      res.ok = 1'b1;
      res.enc_byte = cp[ByteWidth-1:0];
    end else begin
      res.ok = hit;
      res.enc_byte = {1'b1, idx};
    end
    return res;
  endfunction

  // ASCII stand-in for common typographic glyphs; zero when none applies.
  function automatic logic [ByteWidth-1:0] approximate(logic [CpWidth-1:0] cp);
    logic [ByteWidth-1:0] ch;
    case (cp) inside
      21'h2018, 21'h2019, 21'h201A, 21'h201B, 21'h2032: ch = 8'h27;
      21'h201C, 21'h201D, 21'h201E, 21'h201F, 21'h2033: ch = 8'h22;
      21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014,
      21'h2015, 21'h2212:                               ch = 8'h2D;
      21'h2022, 21'h2043:                               ch = 8'h2A;
      21'h2026:                                         ch = 8'h2E;
      21'h00A0, 21'h2000, 21'h2001, 21'h2002, 21'h2003,
      21'h2004, 21'h2005, 21'h2006, 21'h2007, 21'h2008,
      21'h2009, 21'h200A, 21'h202F, 21'h205F, 21'h3000: ch = 8'h20;
      21'h2190:                                         ch = 8'h3C;
      21'h2191:                                         ch = 8'h5E;
      21'h2192:                                         ch = 8'h3E;
      21'h2193, 21'h2713, 21'h2714:                     ch = 8'h76;
      21'h2715, 21'h2716, 21'h00D7:                     ch = 8'h78;
      default:                                          ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* hdl/cp437_encoder_with_fallback_core.sv */
// Code page 437 encoder/decoder with ASCII fallback and replacement glyph.
// Depends on cp437_pkg for word types, the glyph table and lookup functions.

// The core takes one word per cycle when the output side is not stalled and
// returns one result word per input word, in order. The result is registered
// in three register stages: sanitize and approximation lookup, the parallel
// exact-match search against the 128-entry glyph table with result
// selection, and the final byte-to-code-point decode. Throughput
// is one word per cycle; a stall on the output backs up through the stages
// without losing or repeating words. The replacement code point is written
// through cfg_we_i/cfg_wdata_i and should only change while the core is idle.
module cp437_encoder_with_fallback_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cp437_pkg::in_word_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cp437_pkg::out_word_t           out_data_o,
  input  logic                           cfg_we_i,
  input  logic [cp437_pkg::CpWidth-1:0]  cfg_wdata_i
);

  logic [cp437_pkg::CpWidth-1:0] repl_q;

  // Stage 1 registers
  logic                            v1_q;
  logic [0:0]                      op1_q;
  logic [7:0]                      bv1_q;
  logic [cp437_pkg::CpWidth-1:0]   cp1_q;
  logic [cp437_pkg::CpWidth-1:0]   repl1_q;
  logic [7:0]                      approx1_q;

  // Stage 2 registers
  logic       v2_q;
  logic [0:0] ok2_q;
  logic [7:0] byte2_q;
  logic [1:0] kind2_q;

  // Output stage
  logic                  v3_q;
  cp437_pkg::out_word_t  out3_q;

  logic en1, en2, en3;
  logic [cp437_pkg::CpWidth-1:0] cp_san, repl_san;
  cp437_pkg::enc_t               cp_enc, repl_enc;
  logic [0:0]                    ok2_d;
  logic [7:0]                    byte2_d;
  logic [1:0]                    kind2_d;
  cp437_pkg::out_word_t          out3_d;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign cp_san   = cp437_pkg::sanitize(in_data_i.code_point);
  assign repl_san = cp437_pkg::sanitize(repl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= cp437_pkg::ReplResetValue;
    end else if (cfg_we_i) begin
      repl_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q     <= in_data_i.opcode;
      bv1_q     <= in_data_i.byte_value;
      cp1_q     <= cp_san;
      repl1_q   <= repl_san;
      approx1_q <= cp437_pkg::approximate(cp_san);
    end
  end

  // Encodes try an exact match first, then the ASCII stand-in, then the replacement glyph.
  assign cp_enc   = cp437_pkg::encode_exact(cp1_q);
  assign repl_enc = cp437_pkg::encode_exact(repl1_q);

  always_comb begin
    ok2_d   = 1'b1;
    byte2_d = bv1_q;
    kind2_d = cp437_pkg::KIND_EXACT;
    if (op1_q == cp437_pkg::OP_ENCODE) begin
      if (cp_enc.ok) begin
        byte2_d = cp_enc.enc_byte;
      end else if (approx1_q != 8'h00) begin
        byte2_d = approx1_q;
        kind2_d = cp437_pkg::KIND_APPROX;
      end else if (repl_enc.ok) begin
        byte2_d = repl_enc.enc_byte;
        kind2_d = cp437_pkg::KIND_REPL;
      end else begin
        ok2_d   = 1'b0;
        byte2_d = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ok2_q   <= ok2_d;
      byte2_q <= byte2_d;
      kind2_q <= kind2_d;
    end
  end

  always_comb begin
    out3_d.success           = ok2_q;
    out3_d.encoded_byte      = byte2_q;
    out3_d.kind              = kind2_q;
    out3_d.output_code_point = ok2_q[0] ? cp437_pkg::decode_byte(byte2_q)
                                        : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out3_q <= out3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out3_q;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for cp437_encoder_with_fallback_core.
// Depends on cp437_pkg for the word types and the opcode and kind codes.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned StandInCount = 48;

  // Upper half of the code page, kept independently of the design.
  localparam logic [20:0] HIGH_GLYPHS [128] = '{
    21'h00C7, 21'h00FC, 21'h00E9, 21'h00E2, 21'h00E4, 21'h00E0, 21'h00E5, 21'h00E7,
    21'h00EA, 21'h00EB, 21'h00E8, 21'h00EF, 21'h00EE, 21'h00EC, 21'h00C4, 21'h00C5,
    21'h00C9, 21'h00E6, 21'h00C6, 21'h00F4, 21'h00F6, 21'h00F2, 21'h00FB, 21'h00F9,
    21'h00FF, 21'h00D6, 21'h00DC, 21'h00A2, 21'h00A3, 21'h00A5, 21'h20A7, 21'h0192,
    21'h00E1, 21'h00ED, 21'h00F3, 21'h00FA, 21'h00F1, 21'h00D1, 21'h00AA, 21'h00BA,
    21'h00BF, 21'h2310, 21'h00AC, 21'h00BD, 21'h00BC, 21'h00A1, 21'h00AB, 21'h00BB,
    21'h2591, 21'h2592, 21'h2593, 21'h2502, 21'h2524, 21'h2561, 21'h2562, 21'h2556,
    21'h2555, 21'h2563, 21'h2551, 21'h2557, 21'h255D, 21'h255C, 21'h255B, 21'h2510,
    21'h2514, 21'h2534, 21'h252C, 21'h251C, 21'h2500, 21'h253C, 21'h255E, 21'h255F,
    21'h255A, 21'h2554, 21'h2569, 21'h2566, 21'h2560, 21'h2550, 21'h256C, 21'h2567,
    21'h2568, 21'h2564, 21'h2565, 21'h2559, 21'h2558, 21'h2552, 21'h2553, 21'h256B,
    21'h256A, 21'h2518, 21'h250C, 21'h2588, 21'h2584, 21'h258C, 21'h2590, 21'h2580,
    21'h03B1, 21'h00DF, 21'h0393, 21'h03C0, 21'h03A3, 21'h03C3, 21'h00B5, 21'h03C4,
    21'h03A6, 21'h0398, 21'h03A9, 21'h03B4, 21'h221E, 21'h03C6, 21'h03B5, 21'h2229,
    21'h2261, 21'h00B1, 21'h2265, 21'h2264, 21'h2320, 21'h2321, 21'h00F7, 21'h2248,
    21'h00B0, 21'h2219, 21'h00B7, 21'h221A, 21'h207F, 21'h00B2, 21'h25A0, 21'h00A0
  };

  // Typographic glyphs with an ASCII stand-in, plus a few near misses.
  localparam logic [20:0] TYPO_GLYPHS [StandInCount] = '{
    21'h2018, 21'h2019, 21'h201A, 21'h201B, 21'h2032, 21'h201C, 21'h201D, 21'h201E,
    21'h201F, 21'h2033, 21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2015,
    21'h2212, 21'h2022, 21'h2043, 21'h2026, 21'h00A0, 21'h2000, 21'h2001, 21'h2002,
    21'h2003, 21'h2004, 21'h2005, 21'h2006, 21'h2007, 21'h2008, 21'h2009, 21'h200A,
    21'h202F, 21'h205F, 21'h3000, 21'h2190, 21'h2191, 21'h2192, 21'h2193, 21'h2713,
    21'h2714, 21'h2715, 21'h2716, 21'h00D7, 21'h2017, 21'h2027, 21'h2717, 21'h218F
  };

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  cp437_pkg::in_word_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  cp437_pkg::out_word_t out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [20:0]          cfg_wdata_i = '0;

  cp437_pkg::in_word_t  char_queue[$];
  cp437_pkg::out_word_t predicted_chars[$];
  logic [20:0] repl_setting = 21'd63;
  logic        word_taken = 1'b0;
  bit          gaps_on = 1'b1;
  bit          hold_go = 1'b0;
  bit          hold_used = 1'b0;
  int unsigned hold_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned n_decode = 0, n_exact = 0, n_approx = 0, n_repl = 0, n_fail = 0;

  cp437_encoder_with_fallback_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic logic [20:0] clean_cp(logic [20:0] cp);
    if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
      return 21'hFFFD;
    end
    return cp;
  endfunction

  function automatic logic [20:0] byte_to_cp(logic [7:0] b);
    if (b < 8'h80) begin
      return {13'd0, b};
    end
    return HIGH_GLYPHS[b - 8'h80];
  endfunction

  function automatic bit find_byte(logic [20:0] cp, output logic [7:0] b);
    logic [20:0] c;
    c = clean_cp(cp);
    b = 8'h00;
    if (c <= 21'h7F) begin
      b = c[7:0];
      return 1'b1;
    end
    for (int i = 0; i < 128; i++) begin
      if (HIGH_GLYPHS[i] == c) begin
        b = 8'h80 + 8'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] ascii_stand_in(logic [20:0] cp);
    case (clean_cp(cp)) inside
      21'h2018, 21'h2019, 21'h201A, 21'h201B, 21'h2032: return "'";
      21'h201C, 21'h201D, 21'h201E, 21'h201F, 21'h2033: return "\"";
      21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2015, 21'h2212: return "-";
      21'h2022, 21'h2043: return "*";
      21'h2026: return ".";
      21'h00A0, 21'h2000, 21'h2001, 21'h2002, 21'h2003, 21'h2004, 21'h2005, 21'h2006,
      21'h2007, 21'h2008, 21'h2009, 21'h200A, 21'h202F, 21'h205F, 21'h3000: return " ";
      21'h2190: return "<";
      21'h2191: return "^";
      21'h2192: return ">";
      21'h2193, 21'h2713, 21'h2714: return "v";
      21'h2715, 21'h2716, 21'h00D7: return "x";
      default: return 8'h00;
    endcase
  endfunction

  function automatic cp437_pkg::out_word_t convert_char(cp437_pkg::in_word_t w);
    cp437_pkg::out_word_t r;
    logic [7:0]           b;
    logic [7:0]           alt;
    r = '0;
    alt = ascii_stand_in(w.code_point);
    if (w.opcode == cp437_pkg::OP_DECODE) begin
      r.success = 1'b1;
      r.encoded_byte = w.byte_value;
      r.output_code_point = byte_to_cp(w.byte_value);
      r.kind = cp437_pkg::KIND_EXACT;
      return r;
    end
    if (find_byte(w.code_point, b)) begin
      r.success = 1'b1;
      r.kind = cp437_pkg::KIND_EXACT;
    end else if (alt != 8'h00 && find_byte({13'd0, alt}, b)) begin
      r.success = 1'b1;
      r.kind = cp437_pkg::KIND_APPROX;
    end else if (find_byte(repl_setting, b)) begin
      r.success = 1'b1;
      r.kind = cp437_pkg::KIND_REPL;
    end
    if (r.success) begin
      r.encoded_byte = b;
      r.output_code_point = byte_to_cp(b);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic queue_word(logic [0:0] op, logic [20:0] cp, logic [7:0] b);
    cp437_pkg::in_word_t w;
    w.opcode = op;
    w.code_point = cp;
    w.byte_value = b;
    char_queue.push_back(w);
  endtask

  function automatic cp437_pkg::in_word_t random_word();
    cp437_pkg::in_word_t w;
    int unsigned         pick;
    pick = $urandom_range(0, 99);
    w.opcode = cp437_pkg::OP_ENCODE;
    w.code_point = 21'($urandom_range(0, 21'h1FFFFF));
    w.byte_value = 8'($urandom_range(0, 255));
    if (pick < 25) begin
      w.opcode = cp437_pkg::OP_DECODE;
    end else if (pick < 35) begin
      w.code_point = 21'($urandom_range(0, 127));
    end else if (pick < 55) begin
      w.code_point = HIGH_GLYPHS[$urandom_range(0, 127)];
    end else if (pick < 72) begin
      w.code_point = TYPO_GLYPHS[$urandom_range(0, StandInCount - 1)];
    end else if (pick < 80) begin
      w.code_point = 21'($urandom_range(0, 16'hFFFF));
    end else if (pick < 85) begin
      w.code_point = 21'($urandom_range(21'hD7FE, 21'hE001));
    end else if (pick < 92) begin
      w.code_point = 21'($urandom_range(21'h10FFF0, 21'h110010));
    end
    return w;
  endfunction

  task automatic queue_random(int unsigned count);
    repeat (count) char_queue.push_back(random_word());
  endtask

  // Returns once every word is through and the pipeline has had time to empty.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (char_queue.size() != 0 || in_valid_i || predicted_chars.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_replacement(logic [20:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset replacement glyph.
    queue_word(cp437_pkg::OP_DECODE, 21'h1FFFFF, 8'h00);
    queue_word(cp437_pkg::OP_DECODE, 21'h000000, 8'h7F);
    queue_word(cp437_pkg::OP_DECODE, 21'h155555, 8'h80);
    queue_word(cp437_pkg::OP_DECODE, 21'h0AAAAA, 8'hFF);
    queue_word(cp437_pkg::OP_ENCODE, 21'h000000, 8'hFF);
    queue_word(cp437_pkg::OP_ENCODE, 21'h00007F, 8'h00);
    queue_word(cp437_pkg::OP_ENCODE, 21'h000080, 8'h5A);
    queue_word(cp437_pkg::OP_ENCODE, 21'h0000C7, 8'hA5);
    queue_word(cp437_pkg::OP_ENCODE, 21'h0000A0, 8'h00);
    queue_word(cp437_pkg::OP_ENCODE, 21'h002713, 8'hFF);
    queue_word(cp437_pkg::OP_ENCODE, 21'h002026, 8'h11);
    queue_word(cp437_pkg::OP_ENCODE, 21'h002014, 8'h22);
    queue_word(cp437_pkg::OP_ENCODE, 21'h0000D7, 8'h33);
    queue_word(cp437_pkg::OP_ENCODE, 21'h003000, 8'h44);
    queue_word(cp437_pkg::OP_ENCODE, 21'h00D800, 8'h55);
    queue_word(cp437_pkg::OP_ENCODE, 21'h00DFFF, 8'h66);
    queue_word(cp437_pkg::OP_ENCODE, 21'h10FFFF, 8'h77);
    queue_word(cp437_pkg::OP_ENCODE, 21'h110000, 8'h88);
    queue_word(cp437_pkg::OP_ENCODE, 21'h1FFFFF, 8'h99);
    queue_word(cp437_pkg::OP_ENCODE, 21'h00FFFD, 8'hAA);
    queue_word(cp437_pkg::OP_ENCODE, 21'h0025A0, 8'hBB);
    queue_word(cp437_pkg::OP_ENCODE, 21'h0020AC, 8'hCC);
    queue_random(100);
    wait_drained();

    // Replacement at the low extreme: the fallback byte is 0x00.
    write_replacement(21'h000000);
    queue_word(cp437_pkg::OP_ENCODE, 21'h0020AC, 8'h00);
    queue_random(60);
    wait_drained();

    // All ones cannot be encoded, so words without a mapping fail. The output
    // side is held off for a long stretch so the core backs up.
    write_replacement(21'h1FFFFF);
    hold_go = 1'b1;
    queue_random(80);
    wait_drained();

    write_replacement(21'h10FFFF);
    queue_random(60);
    wait_drained();

    // Surrogate replacement, with both sides running back to back.
    write_replacement(21'h00D800);
    gaps_on = 1'b0;
    queue_random(40);
    wait_drained();
    gaps_on = 1'b1;

    write_replacement(21'h002591);
    queue_random(60);
    wait_drained();

    write_replacement(21'h0000A0);
    queue_random(40);
    wait_drained();

    write_replacement(21'($urandom_range(0, 21'h1FFFFF)));
    queue_random(40);
    wait_drained();

    // Closing stretch back at the reset value with no idling on either side.
    write_replacement(21'd63);
    gaps_on = 1'b0;
    queue_random(60);
    wait_drained();

    if (predicted_chars.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", predicted_chars.size()));
    end
    $display("Checked %0d words: %0d decodes, %0d exact, %0d approximated, %0d replaced,",
             n_exact + n_approx + n_repl + n_fail,
             n_decode, n_exact - n_decode, n_approx, n_repl);
    $display("%0d unencodable, over nine replacement settings and a %0d-cycle output hold.",
             n_fail, HoldCycles);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driving

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        gap_left <= $urandom_range(0, 10);
        in_valid_i <= 1'b0;
      end else if (char_queue.size() != 0) begin
        in_data_i <= char_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && hold_left == 0;
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    cp437_pkg::out_word_t want;
    if (rst_ni) begin
      word_taken <= in_valid_i && in_ready_o;
      if (cfg_we_i) begin
        repl_setting <= cfg_wdata_i;
      end
      if (in_valid_i && in_ready_o) begin
        predicted_chars.push_back(convert_char(in_data_i));
        if (in_data_i.opcode == cp437_pkg::OP_DECODE) begin
          n_decode++;
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (predicted_chars.size() == 0) begin
          flag_error($sformatf("unexpected result word %h", out_data_o));
        end else begin
          want = predicted_chars.pop_front();
          if (out_data_o.success !== want.success) begin
            flag_error($sformatf("success %b, expected %b", out_data_o.success, want.success));
          end
          if (out_data_o.encoded_byte !== want.encoded_byte) begin
            flag_error($sformatf("encoded_byte %h, expected %h",
                                 out_data_o.encoded_byte, want.encoded_byte));
          end
          if (out_data_o.output_code_point !== want.output_code_point) begin
            flag_error($sformatf("output_code_point %h, expected %h",
                                 out_data_o.output_code_point, want.output_code_point));
          end
          if (out_data_o.kind !== want.kind) begin
            flag_error($sformatf("kind %0d, expected %0d", out_data_o.kind, want.kind));
          end
          // Decodes report kind exact; they are split out in the summary.
          if (!want.success) begin
            n_fail++;
          end else if (want.kind == cp437_pkg::KIND_APPROX) begin
            n_approx++;
          end else if (want.kind == cp437_pkg::KIND_REPL) begin
            n_repl++;
          end else begin
            n_exact++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, predicted_chars.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
